>>> src/ostk_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the operand stack with reverse.
// No dependencies; imported by every module of the block.
package ostk_pkg;

    localparam int STACK_DEPTH_DEF = 1024;

    localparam int MODE_W   = 3;
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 11;
    localparam int SLOT_W   = 10;
    localparam int FIELD_W  = 11;   // fill and top_slot result fields
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 3'd0,
        MODE_POP   = 3'd1,
        MODE_PEEK  = 3'd2,
        MODE_REV   = 3'd3,
        MODE_CHECK = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_OVERFLOW = 3'd1,
        STS_UNDERFLW = 3'd2,
        STS_REV_LONG = 3'd3,
        STS_RANGE    = 3'd4,
        STS_DEAD     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_SW_RDA,
        ST_SW_RDB,
        ST_SW_WRA,
        ST_SW_WRB
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [WORD_W-1:0]  push_value;
        logic [COUNT_W-1:0] count;
        logic [SLOT_W-1:0]  slot_address;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_value;
        logic [FIELD_W-1:0]  fill;
        logic [FIELD_W-1:0]  top_slot;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

>>> src/ostk_ram.sv
`timescale 1ns / 1ps
// Stack word store: one write port, one read port with registered data.
// Depends on ostk_pkg for the word width.
module ostk_ram
    import ostk_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int IDX_W = $clog2(STACK_DEPTH_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/ostk_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the operand stack: bounds checks, top pointer and swap loop,
// all slot addresses through one shared adder. Depends on ostk_pkg.
module ostk_ctrl
    import ostk_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int IDX_W = $clog2(STACK_DEPTH_DEF),
    parameter int PTR_W = $clog2(STACK_DEPTH_DEF + 1),
    parameter int CMP_W = FIELD_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output rsp_t              rsp,
    output logic              wr_en,
    output logic [IDX_W-1:0]  addr,
    output logic [WORD_W-1:0] wr_data,
    input  logic [WORD_W-1:0] rd_data
);

    localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(DEPTH);
    localparam logic [PTR_W-1:0] EMPTY_P = PTR_W'(DEPTH);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [PTR_W-1:0]  top_reg, top_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    rsp_t              rsp_reg, rsp_next;
    logic              done_reg;

    logic              finish;
    status_t           fin_status;
    logic [WORD_W-1:0] fin_value;

    // shared address adder
    logic [CMP_W-1:0]  off;
    logic [CMP_W-1:0]  sum;

    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  cnt_m1;
    logic [CMP_W-1:0]  fill_w;
    logic [CMP_W-1:0]  slot_w;
    logic [CMP_W-1:0]  top_after;
    logic [CMP_W-1:0]  fill_after;
    logic [IDX_W:0]    lo_plus2;

    assign sum    = CMP_W'(top_reg) + off;
    assign addr   = sum[IDX_W-1:0];
    assign cnt_w  = CMP_W'(cmd_reg.count);
    assign cnt_m1 = cnt_w - CMP_W'(1);
    assign fill_w = DEPTH_W - CMP_W'(top_reg);
    assign slot_w = CMP_W'(cmd_reg.slot_address);
    assign lo_plus2 = {1'b0, lo_reg} + (IDX_W + 1)'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            top_reg   <= EMPTY_P;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tmp_reg <= tmp_next;
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        top_next   = top_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;
        off        = '0;
        wr_en      = 1'b0;
        wr_data    = cmd_reg.push_value;
        finish     = 1'b0;
        fin_status = STS_OK;
        fin_value  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                case (cmd_reg.mode)
                    MODE_PUSH:
                    begin
                        off    = '1;    // top - 1
                        finish = 1'b1;
                        if (top_reg == '0)
                        begin
                            fin_status = STS_OVERFLOW;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            top_next = sum[PTR_W-1:0];
                        end
                    end
                    MODE_POP:
                    begin
                        if (top_reg == EMPTY_P)
                        begin
                            fin_status = STS_UNDERFLW;
                            finish     = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    MODE_PEEK:
                    begin
                        off = cnt_w;
                        if (cnt_w >= fill_w)
                        begin
                            fin_status = STS_RANGE;
                            finish     = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    MODE_REV:
                    begin
                        if (cnt_w > fill_w)
                        begin
                            fin_status = STS_REV_LONG;
                            finish     = 1'b1;
                        end
                        else if (cnt_w < CMP_W'(2))
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = cnt_m1[IDX_W-1:0];
                            state_next = ST_SW_RDA;
                        end
                    end
                    MODE_CHECK:
                    begin
                        finish = 1'b1;
                        if (slot_w < CMP_W'(top_reg) || slot_w >= DEPTH_W)
                        begin
                            fin_status = STS_DEAD;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            ST_READ:
            begin
                finish    = 1'b1;
                fin_value = rd_data;
                if (cmd_reg.mode == MODE_POP)
                begin
                    top_next = top_reg + PTR_W'(1);
                end
            end

            ST_SW_RDA:
            begin
                off        = CMP_W'(lo_reg);
                state_next = ST_SW_RDB;
            end

            ST_SW_RDB:
            begin
                off        = CMP_W'(hi_reg);
                tmp_next   = rd_data;   // lower word
                state_next = ST_SW_WRA;
            end

            ST_SW_WRA:
            begin
                off        = CMP_W'(lo_reg);
                wr_en      = 1'b1;
                wr_data    = rd_data;   // upper word
                state_next = ST_SW_WRB;
            end

            ST_SW_WRB:
            begin
                off     = CMP_W'(hi_reg);
                wr_en   = 1'b1;
                wr_data = tmp_reg;
                lo_next = lo_reg + IDX_W'(1);
                hi_next = hi_reg - IDX_W'(1);
                if (lo_plus2 < {1'b0, hi_reg})
                begin
                    state_next = ST_SW_RDA;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = ST_IDLE;
        end
    end

    assign top_after  = CMP_W'(top_next);
    assign fill_after = DEPTH_W - top_after;

    always_comb
    begin
        rsp_next = rsp_reg;
        if (finish)
        begin
            rsp_next.read_value = fin_value;
            rsp_next.fill       = fill_after[FIELD_W-1:0];
            rsp_next.top_slot   = top_after[FIELD_W-1:0];
            rsp_next.status     = fin_status;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> src/operand_stack_with_reverse.sv
`timescale 1ns / 1ps
// Top level of the operand stack with reverse: sequencer plus word store.
// Depends on ostk_pkg, ostk_ctrl and ostk_ram.
//
//  channel  | ports                | transfer when
//  ---------+----------------------+----------------------------------
//  command  | start, busy, cmd     | rising edge with start & !busy
//  result   | done, rsp            | rising edge ending the done cycle
//
// Steps: push, address check, unused modes and every error finish in the check
// state; pop and peek add one registered read of the store; a reverse of n
// words swaps floor(n/2) pairs, four store accesses per swapped pair through
// the single read and write port.
// The result strobe rises on the cycle busy falls.
// Reset clears the sequencer and sets the stack empty (top slot = depth);
// the store itself is not cleared, as live slots are always pushed first.
// The receiver cannot stall: each result is shown for one cycle only.
module operand_stack_with_reverse
    import ostk_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    // slot index, top pointer (holds depth when empty) and compare widths
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PTR_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

    logic              wr_en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    // one address per cycle: the store's read and write ports share the sequencer's address
    ostk_ctrl #(
        .DEPTH (STACK_DEPTH),
        .IDX_W (IDX_W),
        .PTR_W (PTR_W),
        .CMP_W (CMP_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    ostk_ram #(
        .DEPTH (STACK_DEPTH),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

endmodule
